FILE: hw/rtl/pidpl_pkg.sv
// Shared types and constants for the PID position loop with manual override.
// No dependencies; used by the core and its checker.
package pidpl_pkg;

  typedef logic signed [7:0]  drive_t;
  typedef logic signed [13:0] target_t;
  typedef logic signed [14:0] err_t;
  typedef logic signed [15:0] deriv_t;
  typedef logic signed [23:0] sum_t;
  typedef logic [12:0]        pos_t;

  localparam logic [11:0] UPPER_RAW_LIMIT = 12'd3400;
  localparam logic [11:0] LOWER_RAW_LIMIT = 12'd200;
  localparam logic [14:0] STEP_OFFSET     = 15'd200;
  localparam logic [14:0] TARGET_MAX      = 15'd8191;
  localparam drive_t      DRIVE_MAX       = 8'sd127;
  localparam drive_t      STICK_MIN       = -8'sd128;
  localparam sum_t        SUM_MAX         = 24'sh7FFFFF;
  localparam sum_t        SUM_MIN         = -24'sh800000;

  typedef enum logic [2:0] {
    CFG_GAIN_P,
    CFG_GAIN_I,
    CFG_GAIN_D,
    CFG_ZONE,
    CFG_DEADBAND,
    CFG_OFFSET,
    CFG_LEFT_REV,
    CFG_RIGHT_REV
  } cfg_index_t;

  // drive decision made in the first stage, resolved once the PID sum exists
  typedef struct packed {
    logic   do_drive;
    logic   use_pid;
    drive_t manual;
  } drive_sel_t;

endpackage

FILE: hw/rtl/pid_position_loop_with_manual_override_core.sv
// PID position loop with manual override: one control tick in, one command out.
// Depends on pidpl_pkg.
// Pipeline: decode registers, gain product registers, then the output register (sum).
// Throughput: one tick per cycle unless out_ready stalls the pipeline; loop state
// (target, integral, last error) is updated in the accept cycle. Up to three
// transactions wait while out_ready is low. Reset (rst, synchronous): gains and
// settings to defaults, loop state and held drives to zero, pipeline empty.
module pid_position_loop_with_manual_override_core (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  pidpl_pkg::cfg_index_t   cfg_index,
  input  logic [12:0]             cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [11:0]             raw_sample,
  input  logic                    main_step_up,
  input  logic                    main_step_down,
  input  logic                    partner_step_up,
  input  logic                    partner_step_down,
  input  logic signed [7:0]       stick_value,
  input  logic                    enabled,
  input  logic                    autonomous,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [7:0]       left_drive,
  output logic signed [7:0]       right_drive,
  output logic signed [13:0]      target_position,
  output logic signed [14:0]      position_error
);
  import pidpl_pkg::*;

  // configuration
  logic [9:0]        gain_p, gain_i, gain_d;
  logic [12:0]       integral_zone;
  logic [6:0]        stick_deadband;
  logic signed [12:0] sensor_offset;
  logic              left_reverse, right_reverse;

  // loop state
  target_t target;
  logic    target_loaded;
  sum_t    error_sum;
  err_t    previous_error;
  drive_t  held_left, held_right;

  // pipeline registers
  logic       s1_valid, s2_valid;
  err_t       s1_err, s2_err;
  deriv_t     s1_deriv;
  sum_t       s1_sum;
  target_t    s1_target, s2_target;
  drive_sel_t s1_sel, s2_sel;
  logic signed [26:0] s2_prod_d, s2_prod_p;
  logic signed [34:0] s2_prod_i;

  logic out_free, s2_free, s2_go, s1_go, accept;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;
  assign s2_go     = s2_valid && out_free;
  assign s2_free   = !s2_valid || out_free;
  assign s1_go     = s1_valid && s2_free;
  assign in_ready  = !s1_valid || s2_free;
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p         <= 10'd1;
      gain_i         <= '0;
      gain_d         <= '0;
      integral_zone  <= 13'd100;
      stick_deadband <= 7'd15;
      sensor_offset  <= '0;
      left_reverse   <= 1'b0;
      right_reverse  <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_GAIN_P:    gain_p         <= cfg_data[9:0];
        CFG_GAIN_I:    gain_i         <= cfg_data[9:0];
        CFG_GAIN_D:    gain_d         <= cfg_data[9:0];
        CFG_ZONE:      integral_zone  <= cfg_data;
        CFG_DEADBAND:  stick_deadband <= cfg_data[6:0];
        CFG_OFFSET:    sensor_offset  <= $signed(cfg_data);
        CFG_LEFT_REV:  left_reverse   <= cfg_data[0];
        CFG_RIGHT_REV: right_reverse  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---------------- stage 1: position, error, integral, source select
  logic signed [13:0] pos_raw;
  pos_t               pos;
  target_t            target_cur, target_next;
  err_t               err;
  logic [13:0]        abs_err;
  logic signed [24:0] sum_wide;
  sum_t               sum_sat, error_sum_next;
  deriv_t             deriv;
  drive_t             stick_c, dz;
  logic [14:0]        pos_up;
  logic               up_ok, dn_ok, any_button, button_up, dir_up, dir_dn;
  drive_sel_t         sel;

  always_comb begin
    pos_raw    = $signed({2'b00, raw_sample}) + {sensor_offset[12], sensor_offset};
    pos        = pos_raw[13] ? 13'(-pos_raw) : pos_raw[12:0];
    target_cur = target_loaded ? target : $signed({1'b0, pos});
    err        = {target_cur[13], target_cur} - $signed({2'b00, pos});
    abs_err    = err[14] ? 14'(-err) : err[13:0];

    sum_wide = {error_sum[23], error_sum} + {{10{err[14]}}, err};
    if (sum_wide[24] != sum_wide[23]) sum_sat = sum_wide[24] ? SUM_MIN : SUM_MAX;
    else                              sum_sat = sum_wide[23:0];
    error_sum_next = (abs_err < {1'b0, integral_zone}) ? sum_sat : '0;
    deriv = {err[14], err} - {previous_error[14], previous_error};

    stick_c = (stick_value == STICK_MIN) ? -DRIVE_MAX : stick_value;
    dz      = $signed({1'b0, stick_deadband});
    up_ok   = raw_sample < UPPER_RAW_LIMIT;
    dn_ok   = raw_sample > LOWER_RAW_LIMIT;
    any_button = main_step_up || main_step_down || partner_step_up || partner_step_down;
    button_up  = main_step_up || (!main_step_down && partner_step_up);

    sel    = '{do_drive: 1'b0, use_pid: 1'b0, manual: '0};
    dir_up = 1'b0;
    dir_dn = 1'b0;
    if (enabled && !autonomous) begin
      // a blocked source holds the drive; lower priorities are not tried
      if (any_button) begin
        if (button_up ? up_ok : dn_ok) begin
          sel.do_drive = 1'b1;
          sel.manual   = button_up ? DRIVE_MAX : -DRIVE_MAX;
          dir_up       = button_up;
          dir_dn       = !button_up;
        end
      end else if (stick_c > dz) begin
        if (up_ok) begin
          sel.do_drive = 1'b1;
          sel.manual   = stick_c;
          dir_up       = 1'b1;
        end
      end else if (stick_c < -dz) begin
        if (dn_ok) begin
          sel.do_drive = 1'b1;
          sel.manual   = stick_c;
          dir_dn       = 1'b1;
        end
      end else begin
        sel.do_drive = 1'b1;
        sel.use_pid  = 1'b1;
      end
    end else if (enabled) begin
      sel.do_drive = 1'b1;
      sel.use_pid  = 1'b1;
    end

    pos_up = {2'b00, pos} + STEP_OFFSET;
    if (dir_up)      target_next = (pos_up > TARGET_MAX) ? $signed(TARGET_MAX[13:0])
                                                         : $signed(pos_up[13:0]);
    else if (dir_dn) target_next = $signed({1'b0, pos}) - $signed(STEP_OFFSET[13:0]);
    else             target_next = target_cur;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target         <= '0;
      target_loaded  <= 1'b0;
      error_sum      <= '0;
      previous_error <= '0;
      s1_valid       <= 1'b0;
    end else begin
      if (accept) begin
        target         <= target_next;
        target_loaded  <= 1'b1;
        error_sum      <= error_sum_next;
        previous_error <= err;
        s1_valid       <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_err    <= err;
      s1_deriv  <= deriv;
      s1_sum    <= error_sum_next;
      s1_target <= target_next;
      s1_sel    <= sel;
    end
  end

  // ---------------- stage 2: gain products
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_go) begin
      s2_valid <= 1'b1;
    end else if (s2_go) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      s2_prod_d <= 27'(s1_deriv * $signed({1'b0, gain_d}));
      s2_prod_i <= 35'(s1_sum * $signed({1'b0, gain_i}));
      s2_prod_p <= 27'(s1_err * $signed({1'b0, gain_p}));
      s2_err    <= s1_err;
      s2_target <= s1_target;
      s2_sel    <= s1_sel;
    end
  end

  // ---------------- stage 3: PID sum, saturation, drive hold
  logic signed [35:0] pid_sum;
  drive_t             pid_drive, drive;

  always_comb begin
    pid_sum = {{9{s2_prod_d[26]}}, s2_prod_d} + {s2_prod_i[34], s2_prod_i}
            + {{9{s2_prod_p[26]}}, s2_prod_p};
    if (pid_sum > 36'sd127)       pid_drive = DRIVE_MAX;
    else if (pid_sum < -36'sd127) pid_drive = -DRIVE_MAX;
    else                          pid_drive = pid_sum[7:0];
    drive = s2_sel.use_pid ? pid_drive : s2_sel.manual;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_left  <= '0;
      held_right <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (s2_go) begin
        out_valid <= 1'b1;
        if (s2_sel.do_drive) begin
          held_left  <= left_reverse  ? -drive : drive;
          held_right <= right_reverse ? -drive : drive;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go) begin
      target_position <= s2_target;
      position_error  <= s2_err;
    end
  end

  // held drives only change on the cycle the output register is reloaded
  assign left_drive  = held_left;
  assign right_drive = held_right;

endmodule

FILE: hw/rtl/pidpl_checker.sv
// Port-level checker for the PID position loop core, attached by bind.
// Depends on pidpl_pkg.
module pidpl_checker (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic signed [7:0]  left_drive,
  input logic signed [7:0]  right_drive,
  input logic signed [13:0] target_position,
  input logic signed [14:0] position_error
);
  import pidpl_pkg::*;

  a_empty_after_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result presented straight after reset");

  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (left_drive >= -DRIVE_MAX) && (right_drive >= -DRIVE_MAX))
    else $error("drive command outside +/-127");

  a_target_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> target_position != -14'sd8192)
    else $error("target outside +/-8191");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(left_drive) && $stable(right_drive)
      && $stable(target_position) && $stable(position_error))
    else $error("stalled transaction changed");

endmodule

bind pid_position_loop_with_manual_override_core pidpl_checker u_pidpl_checker (.*);

FILE: dv/pid_position_loop_with_manual_override_core_tb.sv
// Self-checking bench for the PID position loop core: directed ticks, random ticks, then an integral wind-down run.
// Needs pidpl_pkg and pid_position_loop_with_manual_override_core; an in-bench loop
// predictor gives the expected command for every accepted tick that has no typed expectation.
module pid_position_loop_with_manual_override_core_tb;
  import pidpl_pkg::*;

  localparam int LONG_HOLD = 300;
  localparam int SETTLE_CYCLES = 6;
  localparam int MAX_REPORTS = 10;

  localparam logic [3:0] NO_BTN     = 4'b0000;
  localparam logic [3:0] MAIN_UP    = 4'b1000;
  localparam logic [3:0] MAIN_DN    = 4'b0100;
  localparam logic [3:0] PARTNER_UP = 4'b0010;
  localparam logic [3:0] PARTNER_DN = 4'b0001;

  typedef struct packed {
    logic [11:0] raw;
    logic [3:0]  buttons;  // main up, main down, partner up, partner down
    drive_t      stick;
    logic        en;
    logic        aut;
  } tick_t;

  typedef struct packed {
    drive_t  left;
    drive_t  right;
    target_t tgt;
    err_t    err;
  } cmd_t;

  typedef struct {
    int kp, ki, kd, zone, deadband, offset, lrev, rrev;
  } settings_t;

  typedef struct {
    int    setting;
    tick_t t;
    bit    typed;
    cmd_t  want;
  } row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  cfg_index_t        cfg_index = CFG_GAIN_P;
  logic [12:0]       cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [11:0]       raw_sample = '0;
  logic              main_step_up = 1'b0;
  logic              main_step_down = 1'b0;
  logic              partner_step_up = 1'b0;
  logic              partner_step_down = 1'b0;
  logic signed [7:0] stick_value = '0;
  logic              enabled = 1'b0;
  logic              autonomous = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic signed [7:0] left_drive;
  logic signed [7:0] right_drive;
  logic signed [13:0] target_position;
  logic signed [14:0] position_error;

  pid_position_loop_with_manual_override_core u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .raw_sample(raw_sample),
    .main_step_up(main_step_up),
    .main_step_down(main_step_down),
    .partner_step_up(partner_step_up),
    .partner_step_down(partner_step_down),
    .stick_value(stick_value),
    .enabled(enabled),
    .autonomous(autonomous),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .left_drive(left_drive),
    .right_drive(right_drive),
    .target_position(target_position),
    .position_error(position_error)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // loop state mirrored from the block
  settings_t active;
  settings_t presets [3];
  int        loop_target = 0;
  bit        target_loaded = 1'b0;
  int        error_sum = 0;
  int        last_error = 0;
  int        held_left = 0;
  int        held_right = 0;

  cmd_t      pending_cmds [$];
  row_t      rows [$];
  int        mismatches = 0;
  int        burst_left = 0;
  bit        hold_request = 1'b0;

  function automatic cmd_t advance_loop(tick_t t);
    int     raw, stick, pos, err, mag, deriv, drv, dirn;
    longint acc, pid;
    bit     drive_now, up, up_ok, dn_ok;
    cmd_t   c;
    raw = int'(t.raw);
    stick = int'(t.stick);
    drv = 0;
    dirn = 0;
    drive_now = 1'b0;
    if (stick < -int'(DRIVE_MAX)) stick = -int'(DRIVE_MAX);
    pos = raw + active.offset;
    if (pos < 0) pos = -pos;
    if (!target_loaded) begin
      loop_target = pos;
      target_loaded = 1'b1;
    end
    err = loop_target - pos;
    mag = (err < 0) ? -err : err;
    // integral only winds up inside the zone, cleared outside it
    if (mag < active.zone) begin
      acc = longint'(error_sum) + err;
      if (acc > longint'(SUM_MAX)) acc = longint'(SUM_MAX);
      else if (acc < longint'(SUM_MIN)) acc = longint'(SUM_MIN);
      error_sum = int'(acc);
    end else begin
      error_sum = 0;
    end
    deriv = err - last_error;
    last_error = err;
    pid = longint'(deriv) * active.kd + longint'(error_sum) * active.ki
        + longint'(err) * active.kp;
    if (pid > longint'(DRIVE_MAX)) pid = longint'(DRIVE_MAX);
    else if (pid < -longint'(DRIVE_MAX)) pid = -longint'(DRIVE_MAX);

    if (t.en && !t.aut) begin
      up_ok = raw < int'(UPPER_RAW_LIMIT);
      dn_ok = raw > int'(LOWER_RAW_LIMIT);
      // the chosen source alone decides; a blocked one holds the drive
      if (t.buttons != NO_BTN) begin
        up = t.buttons[3] || (!t.buttons[2] && t.buttons[1]);
        if (up ? up_ok : dn_ok) begin
          drv = up ? int'(DRIVE_MAX) : -int'(DRIVE_MAX);
          dirn = up ? 1 : -1;
          drive_now = 1'b1;
        end
      end else if (stick > active.deadband) begin
        if (up_ok) begin
          drv = stick;
          dirn = 1;
          drive_now = 1'b1;
        end
      end else if (stick < -active.deadband) begin
        if (dn_ok) begin
          drv = stick;
          dirn = -1;
          drive_now = 1'b1;
        end
      end else begin
        drv = int'(pid);
        drive_now = 1'b1;
      end
    end else if (t.en) begin
      drv = int'(pid);
      drive_now = 1'b1;
    end

    if (dirn > 0) begin
      loop_target = pos + int'(STEP_OFFSET);
      if (loop_target > int'(TARGET_MAX)) loop_target = int'(TARGET_MAX);
    end else if (dirn < 0) begin
      loop_target = pos - int'(STEP_OFFSET);
    end
    if (drive_now) begin
      held_left = active.lrev ? -drv : drv;
      held_right = active.rrev ? -drv : drv;
    end
    c.left = held_left[7:0];
    c.right = held_right[7:0];
    c.tgt = loop_target[13:0];
    c.err = err[14:0];
    return c;
  endfunction

  function automatic tick_t mk(int raw, logic [3:0] btn, int stick, bit en, bit aut);
    tick_t t;
    t.raw = raw[11:0];
    t.buttons = btn;
    t.stick = stick[7:0];
    t.en = en;
    t.aut = aut;
    return t;
  endfunction

  function automatic cmd_t mkc(int l, int r, int tg, int e);
    cmd_t c;
    c.left = l[7:0];
    c.right = r[7:0];
    c.tgt = tg[13:0];
    c.err = e[14:0];
    return c;
  endfunction

  function automatic void add_row(int setting, tick_t t, bit typed = 1'b0, cmd_t want = '0);
    row_t r;
    r.setting = setting;
    r.t = t;
    r.typed = typed;
    r.want = want;
    rows.push_back(r);
  endfunction

  function automatic int pick_gain();
    int g;
    case ($urandom_range(0, 3))
      0: g = $urandom_range(0, 4);
      1: g = $urandom_range(0, 64);
      2: g = 1023;
      default: g = $urandom_range(0, 1023);
    endcase
    return g;
  endfunction

  function automatic settings_t random_settings();
    settings_t s;
    s.kp = pick_gain();
    s.ki = pick_gain();
    s.kd = pick_gain();
    s.zone = $urandom_range(0, 1) ? $urandom_range(0, 400) : $urandom_range(0, 8191);
    s.deadband = $urandom_range(0, 127);
    s.offset = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 8190)) - 4095;
    s.lrev = $urandom_range(0, 1);
    s.rrev = $urandom_range(0, 1);
    return s;
  endfunction

  function automatic tick_t random_tick();
    int         raw, stick;
    logic [3:0] btn;
    case ($urandom_range(0, 3))
      0: raw = 3398 + $urandom_range(0, 3);
      1: raw = 199 + $urandom_range(0, 3);
      default: raw = $urandom_range(0, 4095);
    endcase
    case ($urandom_range(0, 3))
      0: btn = 4'($urandom_range(0, 15));
      1: btn = 4'b0001 << $urandom_range(0, 3);
      default: btn = NO_BTN;
    endcase
    case ($urandom_range(0, 2))
      0: stick = $urandom_range(0, 255);
      1: begin
        stick = active.deadband + $urandom_range(0, 2) - 1;
        if ($urandom_range(0, 1)) stick = -stick;
      end
      default: stick = int'($urandom_range(0, 20)) - 10;
    endcase
    return mk(raw, btn, stick, $urandom_range(0, 7) != 0, $urandom_range(0, 3) == 0);
  endfunction

  // tick that cannot move the target: disabled, or autonomous
  function automatic tick_t windup_tick(int raw);
    bit en;
    en = 1'($urandom_range(0, 1));
    return mk(raw, 4'($urandom_range(0, 15)), $urandom_range(0, 255), en,
              en ? 1'b1 : 1'($urandom_range(0, 1)));
  endfunction

  task automatic send_tick(tick_t t, bit typed = 1'b0, cmd_t want = '0);
    cmd_t model;
    in_valid <= 1'b1;
    raw_sample <= t.raw;
    {main_step_up, main_step_down, partner_step_up, partner_step_down} <= t.buttons;
    stick_value <= t.stick;
    enabled <= t.en;
    autonomous <= t.aut;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    model = advance_loop(t);
    pending_cmds.push_back(typed ? want : model);
  endtask

  // sender bursts with random gaps in between
  task automatic pace();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    burst_left--;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_index_t idx, int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[12:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_GAIN_P:    active.kp = value;
      CFG_GAIN_I:    active.ki = value;
      CFG_GAIN_D:    active.kd = value;
      CFG_ZONE:      active.zone = value;
      CFG_DEADBAND:  active.deadband = value;
      CFG_OFFSET:    active.offset = value;
      CFG_LEFT_REV:  active.lrev = value;
      CFG_RIGHT_REV: active.rrev = value;
      default: ;
    endcase
  endtask

  task automatic write_settings(settings_t s);
    cfg_write(CFG_GAIN_P, s.kp);
    cfg_write(CFG_GAIN_I, s.ki);
    cfg_write(CFG_GAIN_D, s.kd);
    cfg_write(CFG_ZONE, s.zone);
    cfg_write(CFG_DEADBAND, s.deadband);
    cfg_write(CFG_OFFSET, s.offset);
    cfg_write(CFG_LEFT_REV, s.lrev);
    cfg_write(CFG_RIGHT_REV, s.rrev);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int cur;
    presets[0] = '{1, 0, 0, 100, 15, 0, 0, 0};
    presets[1] = '{1023, 1023, 1023, 8191, 127, -4095, 1, 0};
    presets[2] = '{0, 0, 0, 0, 0, 4095, 0, 1};
    active = presets[0];

    // reset values; first tick loads the target
    add_row(0, mk(1000, NO_BTN, 0, 1, 0), 1, mkc(0, 0, 1000, 0));
    add_row(0, mk(1000, MAIN_UP, 0, 1, 0), 1, mkc(127, 127, 1200, 0));
    add_row(0, mk(1000, MAIN_DN, 0, 1, 0), 1, mkc(-127, -127, 800, 200));
    add_row(0, mk(3400, MAIN_UP, 0, 1, 0), 1, mkc(-127, -127, 800, -2600));
    add_row(0, mk(200, PARTNER_DN, 0, 1, 0), 1, mkc(-127, -127, 800, 600));
    add_row(0, mk(3399, PARTNER_UP, 0, 1, 0), 1, mkc(127, 127, 3599, -2599));
    add_row(0, mk(201, MAIN_UP | MAIN_DN, 0, 1, 0), 1, mkc(127, 127, 401, 3398));
    add_row(0, mk(1000, NO_BTN, -128, 1, 0), 1, mkc(-127, -127, 800, -599));
    add_row(0, mk(4095, NO_BTN, 127, 1, 0), 1, mkc(-127, -127, 800, -3295));
    add_row(0, mk(0, NO_BTN, 16, 1, 0), 1, mkc(16, 16, 200, 800));
    add_row(0, mk(0, NO_BTN, 15, 1, 0), 1, mkc(127, 127, 200, 200));
    add_row(0, mk(4095, NO_BTN, -16, 1, 0), 1, mkc(-16, -16, 3895, -3895));
    add_row(0, mk(3895, MAIN_UP, 0, 0, 0), 1, mkc(-16, -16, 3895, 0));
    add_row(0, mk(3800, MAIN_UP, 0, 1, 1), 1, mkc(95, 95, 3895, 95));
    add_row(0, mk(3895, NO_BTN, -15, 1, 0), 1, mkc(0, 0, 3895, 0));
    // top gains, widest zone and deadband, offset -4095
    add_row(1, mk(0, NO_BTN, 127, 1, 0));
    add_row(1, mk(4095, NO_BTN, -128, 1, 0));
    add_row(1, mk(4095, PARTNER_DN, 0, 1, 0));
    add_row(1, mk(0, MAIN_UP, 0, 1, 0));
    add_row(1, mk(4095, 4'b1111, -128, 1, 0));
    add_row(1, mk(2048, NO_BTN, 0, 1, 1));
    // zero gains, zone and deadband, highest offset
    add_row(2, mk(4095, NO_BTN, 1, 1, 0));
    add_row(2, mk(3399, NO_BTN, 1, 1, 0));
    add_row(2, mk(201, NO_BTN, -1, 1, 0));
    add_row(2, mk(100, NO_BTN, 0, 1, 0));
    add_row(2, mk(3896, MAIN_UP, 0, 1, 0));

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    cur = 0;
    foreach (rows[i]) begin
      if (rows[i].setting != cur) begin
        settle();
        write_settings(presets[rows[i].setting]);
        cur = rows[i].setting;
      end
      pace();
      send_tick(rows[i].t, rows[i].typed, rows[i].want);
    end

    for (int ph = 0; ph < 4; ph++) begin
      settle();
      write_settings(random_settings());
      repeat (20) begin
        pace();
        send_tick(random_tick());
      end
    end

    // drive the integral into its lower bound: target below zero, position near the top
    settle();
    write_settings('{1, 0, 0, 100, 15, -4095, 0, 0});
    send_tick(mk(4095, MAIN_DN, 0, 1, 0));
    settle();
    write_settings('{2, 1023, 1023, 8191, 127, 4095, 0, 1});
    hold_request = 1'b1;
    repeat (1045) begin
      pace();
      send_tick(windup_tick(3845 + $urandom_range(0, 50)));
    end

    settle();
    if (mismatches == 0 && pending_cmds.size() == 0) begin
      $display("pid_position_loop_with_manual_override_core_tb OK");
    end else begin
      $display("pid_position_loop_with_manual_override_core_tb NOT OK");
    end
    $finish;
  end

  // receiver: stall patterns of random length, plus one long hold-off
  initial begin
    int mode, len;
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      len = $urandom_range(1, 30);
      for (int k = 0; k < len; k++) begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 3) != 0);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    cmd_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_cmds.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected transaction: l=%0d r=%0d tgt=%0d err=%0d",
                   left_drive, right_drive, target_position, position_error);
      end else begin
        want = pending_cmds.pop_front();
        if (left_drive !== want.left || right_drive !== want.right ||
            target_position !== want.tgt || position_error !== want.err) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: want l=%0d r=%0d tgt=%0d err=%0d, got l=%0d r=%0d tgt=%0d err=%0d",
                     want.left, want.right, want.tgt, want.err,
                     left_drive, right_drive, target_position, position_error);
        end
      end
    end
  end

  initial begin
    #1000000;
    $display("pid_position_loop_with_manual_override_core_tb NOT OK");
    $finish;
  end

endmodule
